// ----- hdl/fdlp_pkg.sv -----
// Package for the length-prefixed field deframer.
// Holds the word types, the parse mode enum and the character constants.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package fdlp_pkg;

	// One received word: a character and a failed-read mark.
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       read_failed;
	} item_t;

	// One result word: a stored data byte or the end of a field.
	typedef struct packed {
		logic       is_end;
		logic [7:0] data_byte;
		logic       packet_end;
		logic       read_error;
		logic [5:0] field_length;
		logic       overflowed;
	} result_t;

	// Result of parsing one word, passed from the parser to the output register.
	typedef struct packed {
		logic    valid;
		result_t res;
	} step_t;

	typedef enum logic [1:0] {
		MODE_START   = 2'd0,
		MODE_PLAIN   = 2'd1,
		MODE_LENGTH  = 2'd2,
		MODE_LITERAL = 2'd3
	} mode_t;

	localparam logic [7:0]  CH_LBRACKET = 8'h5B;
	localparam logic [7:0]  CH_RBRACKET = 8'h5D;
	localparam logic [7:0]  CH_SEMI     = 8'h3B;
	localparam logic [7:0]  CH_NEWLINE  = 8'h0A;
	localparam logic [7:0]  CH_ZERO     = 8'h30;
	localparam logic [15:0] LEN_RADIX   = 16'd10;

endpackage

`default_nettype wire

// ----- hdl/field_deframer_length_prefixed_top.sv -----
// Top level of the length-prefixed field deframer: input register, parser, result register.
// Depends on fdlp_pkg, fdlp_parse and fdlp_out_reg.
//
//   channel | handshake                   | word     | per word
//   --------+-----------------------------+----------+------------------------------
//   item    | item_valid / item_stall     | item_t   | one received character
//   result  | result_valid / result_stall | result_t | zero or one data/end word
//
// Each word waits in the input register and moves to the result register when that
// register can take it; a new word is taken every cycle while results flow.
// A result is registered: it is visible in the result register and is taken at an
// edge where result_stall is low.
// Reset clears the field state and both valid flags; no clearing pass is needed.
// A stall on the result side holds the result register and the input register,
// and item_stall rises only when the input register is full and cannot advance.
`default_nettype none

module field_deframer_length_prefixed_top #(
	parameter int BUFFER_BYTES = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire fdlp_pkg::item_t   item,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output fdlp_pkg::result_t      result
);
	import fdlp_pkg::*;

	// Input register stage: the word under decode.
	logic    valid_s1;
	item_t   item_s1;

	logic    can_load;
	logic    advance;
	step_t   step;

	// The stage advances whenever the result register can take a new word,
	// whether or not this word yields a result.
	assign advance    = valid_s1 && can_load;
	assign item_stall = valid_s1 && !can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

	// Field state and decode of the word in the input register.
	fdlp_parse #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item_s1 (item_s1),
		.step    (step)
	);

	// Result register that parts the two sides of the block.
	fdlp_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (advance),
		.step         (step),
		.can_load     (can_load),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

`default_nettype wire

// ----- hdl/fdlp_parse.sv -----
// Parser of the length-prefixed field deframer: field state and per-word decode.
// Depends on fdlp_pkg for the word types, the mode enum and the characters.
`default_nettype none

module fdlp_parse #(
	parameter int BUFFER_BYTES = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           advance,
	input  wire fdlp_pkg::item_t item_s1,
	output fdlp_pkg::step_t     step
);
	import fdlp_pkg::*;

	localparam int CW = $clog2(BUFFER_BYTES);

	mode_t          mode_q, mode_d;
	logic [15:0]    len_q, len_d;
	logic [CW-1:0]  stored_q, stored_d;
	logic           drop_q, drop_d;

	logic           do_end;
	logic           end_pkt;
	logic           do_store;
	logic           go_plain;
	logic [15:0]    len_dec;
	logic [CW+5:0]  stored_ext;
	logic [7:0]     b;

	assign b          = item_s1.rx_byte;
	assign len_dec    = len_q - 16'd1;
	assign stored_ext = {6'd0, stored_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_START;
			len_q    <= '0;
			stored_q <= '0;
			drop_q   <= 1'b0;
		end else if (advance) begin
			mode_q   <= mode_d;
			len_q    <= len_d;
			stored_q <= stored_d;
			drop_q   <= drop_d;
		end
	end

	always_comb begin
		mode_d   = mode_q;
		len_d    = len_q;
		stored_d = stored_q;
		drop_d   = drop_q;
		do_end   = 1'b0;
		end_pkt  = 1'b0;
		do_store = 1'b0;
		go_plain = 1'b0;
		step     = '0;

		if (!item_s1.read_failed) begin
			unique case (mode_q)
				MODE_START: begin
					if (b == CH_LBRACKET) begin
						mode_d = MODE_LENGTH;
						len_d  = '0;
					end else begin
						go_plain = 1'b1;
					end
				end
				MODE_LENGTH: begin
					if (b == CH_RBRACKET) begin
						mode_d = (len_q == 16'd0) ? MODE_PLAIN : MODE_LITERAL;
					end else begin
						len_d = 16'(len_q * LEN_RADIX) + {8'd0, b} - {8'd0, CH_ZERO};
					end
				end
				MODE_LITERAL: begin
					len_d    = len_dec;
					do_store = 1'b1;
					if (len_dec == 16'd0) begin
						mode_d = MODE_PLAIN;
					end
				end
				MODE_PLAIN: begin
					go_plain = 1'b1;
				end
				default: begin
					go_plain = 1'b1;
				end
			endcase
		end else begin
			do_end = 1'b1;
		end

		// Separators close the field; anything else is content.
		if (go_plain) begin
			if (b == CH_SEMI) begin
				do_end = 1'b1;
			end else if (b == CH_NEWLINE) begin
				do_end  = 1'b1;
				end_pkt = 1'b1;
			end else begin
				mode_d   = MODE_PLAIN;
				do_store = 1'b1;
			end
		end

		if (do_store) begin
			if (stored_q < CW'(BUFFER_BYTES - 1)) begin
				stored_d            = stored_q + 1'b1;
				step.valid          = 1'b1;
				step.res.data_byte  = b;
			end else begin
				drop_d = 1'b1;
			end
		end

		if (do_end) begin
			step.valid             = 1'b1;
			step.res.is_end        = 1'b1;
			step.res.packet_end    = end_pkt;
			step.res.read_error    = item_s1.read_failed;
			step.res.field_length  = stored_ext[5:0];
			step.res.overflowed    = drop_q;
			mode_d   = MODE_START;
			len_d    = '0;
			stored_d = '0;
			drop_d   = 1'b0;
		end
	end

	// The stored count never reaches the buffer size.
	a_stored_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stored_q <= CW'(BUFFER_BYTES - 1))
		else $error("stored count beyond buffer");

	// Literal copying always has bytes left to copy.
	a_literal_len: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_LITERAL) |-> (len_q != 16'd0))
		else $error("literal mode with zero length");

	// A field end clears the whole field state.
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && step.valid && step.res.is_end) |=>
		(mode_q == MODE_START && stored_q == '0 && !drop_q && len_q == 16'd0))
		else $error("field state not cleared after end");

	// Overflow is only flagged once the buffer is full.
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(drop_q) |-> (stored_q == CW'(BUFFER_BYTES - 1)))
		else $error("drop flagged with room left");

endmodule

`default_nettype wire

// ----- hdl/fdlp_out_reg.sv -----
// Result register of the length-prefixed field deframer.
// Depends on fdlp_pkg for the result word type; holds one word while stalled.
`default_nettype none

module fdlp_out_reg (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire fdlp_pkg::step_t  step,
	output logic                  can_load,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output fdlp_pkg::result_t     result
);
	import fdlp_pkg::*;

	logic    valid_q;
	result_t data_q;

	assign can_load     = !valid_q || !result_stall;
	assign result_valid = valid_q;
	assign result       = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load && step.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && load && step.valid) begin
			data_q <= step.res;
		end
	end

endmodule

`default_nettype wire
